/* rtl/tsp_pkg.sv */
// Shared types, codes and constants for the time span text parser.
`timescale 1ns / 1ps

package tsp_pkg;

  // Default width of the character position counters
  localparam int DEF_POSITION_WIDTH = 16;

  // Character codes
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;

  // Parse phases; a number phase is odd once a sign or digit was seen
  localparam logic [3:0] PH_LEAD     = 4'd0;
  localparam logic [3:0] PH_DONE     = 4'd1;
  localparam logic [3:0] PH_FIRST    = 4'd2;
  localparam logic [3:0] PH_HOURS    = 4'd4;
  localparam logic [3:0] PH_MINUTES  = 4'd6;
  localparam logic [3:0] PH_SECONDS  = 4'd8;
  localparam logic [3:0] PH_FRACTION = 4'd10;
  localparam logic [3:0] PH_NUM_LAST = 4'd11;

  // Number index within the string
  localparam logic [2:0] K_FIRST   = 3'd0;
  localparam logic [2:0] K_HOURS   = 3'd1;
  localparam logic [2:0] K_MINUTES = 3'd2;
  localparam logic [2:0] K_SECONDS = 3'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_COLON = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Range limits
  localparam logic [31:0] MAX_HOUR     = 32'd23;
  localparam logic [31:0] MAX_MIN_SEC  = 32'd59;
  localparam logic [31:0] MAX_FRACTION = 32'd9999999;

  // Tick scaling
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [23:0] TICKS_PER_SEC = 24'(1000 * 10000);
  localparam logic [39:0] TICKS_PER_DAY = 40'd864000000000;
  localparam int          DAY_SPLIT     = 20;
  localparam logic [19:0] TPD_LO        = TICKS_PER_DAY[19:0];
  localparam logic [19:0] TPD_HI        = TICKS_PER_DAY[39:20];

  // Fields of a finished string, handed from the parser to the tick pipeline
  typedef struct packed {
    logic [1:0]  status;
    logic        neg;
    logic [30:0] day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [23:0] frac;
    logic [15:0] stop;
  } tsp_rec_t;

  // Result word fields, status in the lowest bits
  typedef struct packed {
    logic [15:0] stop;
    logic [63:0] ticks;
    logic [1:0]  status;
  } tsp_res_t;

endpackage

/* rtl/tsp_parser.sv */
// Character-by-character parse of the span text into day, h, m, s and fraction.
`timescale 1ns / 1ps

module tsp_parser import tsp_pkg::*; #(
  parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char,
  input  logic        in_present,
  input  logic        in_last,
  output logic        rec_valid,
  input  logic        rec_ready,
  output tsp_rec_t    rec
);

  localparam int PW = POSITION_WIDTH;

  typedef struct packed {
    logic [3:0]    phase;
    logic          span_neg;
    logic          num_neg;
    logic [31:0]   acc;
    logic [30:0]   day;
    logic [4:0]    hour;
    logic [5:0]    minute;
    logic [5:0]    second;
    logic [23:0]   frac;
    logic [1:0]    err;
    logic [PW-1:0] stop;
    logic [PW-1:0] first;
  } pstate_t;

  pstate_t       st;
  logic [PW-1:0] pos;
  pstate_t       s_char;
  pstate_t       s_end;
  logic [PW-1:0] pos_next;
  logic [15:0]   stop16;
  logic          take;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] p);
    return (p == '1) ? p : p + PW'(1);
  endfunction

  function automatic pstate_t stop_at(input pstate_t s, input logic [1:0] code,
                                      input logic [PW-1:0] p);
    pstate_t n;
    n = s;
    n.err = code;
    n.stop = p;
    n.phase = PH_DONE;
    return n;
  endfunction

  function automatic pstate_t start_num(input pstate_t s, input logic [3:0] ph);
    pstate_t n;
    n = s;
    n.acc = '0;
    n.num_neg = 1'b0;
    n.phase = ph;
    return n;
  endfunction

  function automatic pstate_t finish(input pstate_t s, input logic [23:0] f,
                                     input logic [PW-1:0] p);
    pstate_t n;
    n = s;
    n.frac = f;
    n.err = ST_OK;
    n.stop = p;
    n.phase = PH_DONE;
    return n;
  endfunction

  // One parse step; has low means end of string
  function automatic pstate_t feed(input pstate_t s, input logic has,
                                   input logic [15:0] c, input logic [PW-1:0] p);
    pstate_t     n;
    logic        blank;
    logic        minus;
    logic        digit;
    logic        dot;
    logic        colon;
    logic        run;
    logic        skip;
    logic        ok;
    logic [2:0]  k;
    logic [3:0]  rel;
    logic [35:0] acc10;
    logic [31:0] v;
    n = s;
    blank = has && (c == CH_SPACE || c == CH_TAB);
    minus = has && (c == CH_MINUS);
    digit = has && (c >= CH_ZERO) && (c <= CH_NINE);
    dot = has && (c == CH_DOT);
    colon = has && (c == CH_COLON);
    run = 1'b1;

    // Leading blanks and the span sign
    if (s.phase == PH_LEAD) begin
      if (blank) begin
        run = 1'b0;
      end else if (minus) begin
        n.span_neg = 1'b1;
        n.first = sat_inc(p);
        n = start_num(n, PH_FIRST);
        run = 1'b0;
      end else begin
        n.first = p;
        n = start_num(n, PH_FIRST);
      end
    end

    rel = n.phase - PH_FIRST;
    k = rel[3:1];
    skip = !n.phase[0] && blank;
    acc10 = ({4'b0, n.acc} << 3) + ({4'b0, n.acc} << 1) + 36'(c[3:0]);
    ok = n.num_neg ? (n.acc == '0) : !n.acc[31];
    v = n.num_neg ? '0 : n.acc;

    if (run && n.phase >= PH_FIRST && n.phase <= PH_NUM_LAST && !skip) begin
      priority if (!n.phase[0] && minus) begin
        n.num_neg = 1'b1;
        n.phase[0] = 1'b1;
      end else if (digit) begin
        if (|acc10[35:32]) begin
          n = stop_at(n, ST_INVALID, p);
        end else begin
          n.acc = acc10[31:0];
          n.phase[0] = 1'b1;
        end
      end else begin
        // Number ends here: range check and separator
        unique case (k)
          K_FIRST: begin
            if (!ok) begin
              n = stop_at(n, ST_INVALID, p);
            end else if (dot) begin
              n.day = v[30:0];
              n = start_num(n, PH_HOURS);
            end else if (v > MAX_HOUR) begin
              n = stop_at(n, ST_INVALID, n.first);
            end else begin
              n.hour = v[4:0];
              n.day = '0;
              n = colon ? start_num(n, PH_MINUTES) : stop_at(n, ST_NO_COLON, p);
            end
          end
          K_HOURS: begin
            if (!ok || v > MAX_HOUR) begin
              n = stop_at(n, ST_INVALID, p);
            end else begin
              n.hour = v[4:0];
              n = colon ? start_num(n, PH_MINUTES) : stop_at(n, ST_NO_COLON, p);
            end
          end
          K_MINUTES: begin
            if (!ok || v > MAX_MIN_SEC) begin
              n = stop_at(n, ST_INVALID, p);
            end else begin
              n.minute = v[5:0];
              n = colon ? start_num(n, PH_SECONDS) : stop_at(n, ST_NO_COLON, p);
            end
          end
          K_SECONDS: begin
            if (!ok || v > MAX_MIN_SEC) begin
              n = stop_at(n, ST_INVALID, p);
            end else begin
              n.second = v[5:0];
              n = dot ? start_num(n, PH_FRACTION) : finish(n, '0, p);
            end
          end
          default: begin
            if (!ok || v > MAX_FRACTION) begin
              n = stop_at(n, ST_INVALID, p);
            end else begin
              n = finish(n, v[23:0], p);
            end
          end
        endcase
      end
    end
    return n;
  endfunction

  // Step on the character, then on the end of string
  assign take     = in_valid && in_ready;
  assign pos_next = in_present ? sat_inc(pos) : pos;
  assign s_char   = in_present ? feed(st, 1'b1, in_char, pos) : st;
  assign s_end    = feed(s_char, 1'b0, '0, pos_next);

  // Saturate the stop point to the result field
  generate
    if (PW > 16) begin : g_sat
      assign stop16 = (|s_end.stop[PW-1:16]) ? 16'hFFFF : s_end.stop[15:0];
    end else begin : g_ext
      assign stop16 = 16'(s_end.stop);
    end
  endgenerate

  assign in_ready   = rec_ready;
  assign rec_valid  = in_valid && in_last;
  assign rec.status = s_end.err;
  assign rec.neg    = s_end.span_neg;
  assign rec.day    = s_end.day;
  assign rec.hour   = s_end.hour;
  assign rec.minute = s_end.minute;
  assign rec.second = s_end.second;
  assign rec.frac   = s_end.frac;
  assign rec.stop   = stop16;

  // Advance parse state; clear it after the last word of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      pos <= '0;
    end else if (take) begin
      if (in_last) begin
        st  <= '0;
        pos <= '0;
      end else begin
        st  <= s_char;
        pos <= pos_next;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> st.phase == PH_LEAD && pos == '0)
    else $error("parse state not cleared after end of string");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> s_end.phase == PH_DONE)
    else $error("end of string left parse unfinished");

endmodule

/* rtl/tsp_ticks.sv */
// Tick total pipeline: scale day and h:m:s, add, check overflow, apply sign.
`timescale 1ns / 1ps

module tsp_ticks import tsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     rec_valid,
  output logic     rec_ready,
  input  tsp_rec_t rec,
  output logic     out_valid,
  input  logic     out_ready,
  output tsp_res_t res
);

  localparam int DP = 31 + DAY_SPLIT;

  logic          a_v, b_v, c_v, o_v;
  logic          a_rdy, b_rdy, c_rdy, o_adv;
  logic [DP-1:0] a_day_lo, a_day_hi;
  logic [16:0]   a_hms;
  logic [23:0]   a_frac, b_frac;
  logic          a_neg, b_neg, c_neg;
  logic [1:0]    a_st, b_st, c_st;
  logic [15:0]   a_stop, b_stop, c_stop;
  logic [70:0]   b_day;
  logic [40:0]   b_rest;
  logic [71:0]   c_sum;
  logic [62:0]   c_total;
  logic          c_ovf;
  logic [1:0]    st_final;
  logic [63:0]   mag;
  tsp_res_t      res_next;

  // Stall chain: a stage moves when the one after it is empty or moving
  assign o_adv     = !o_v || out_ready;
  assign c_rdy     = !c_v || o_adv;
  assign b_rdy     = !b_v || c_rdy;
  assign a_rdy     = !a_v || b_rdy;
  assign rec_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= rec_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (o_adv) o_v <= c_v;
    end
  end

  // Stage a: split day product, seconds of the day
  always_ff @(posedge clk) begin
    if (a_rdy && rec_valid) begin
      a_day_lo <= DP'(rec.day) * DP'(TPD_LO);
      a_day_hi <= DP'(rec.day) * DP'(TPD_HI);
      a_hms    <= 17'(rec.hour) * SECS_PER_HOUR + 17'(rec.minute) * SECS_PER_MIN
                  + 17'(rec.second);
      a_frac   <= rec.frac;
      a_neg    <= rec.neg;
      a_st     <= rec.status;
      a_stop   <= rec.stop;
    end
  end

  // Stage b: join day product, scale seconds to ticks
  always_ff @(posedge clk) begin
    if (b_rdy && a_v) begin
      b_day  <= {a_day_hi, {DAY_SPLIT{1'b0}}} + 71'(a_day_lo);
      b_rest <= 41'(a_hms) * 41'(TICKS_PER_SEC);
      b_frac <= a_frac;
      b_neg  <= a_neg;
      b_st   <= a_st;
      b_stop <= a_stop;
    end
  end

  // Stage c: total and overflow above the signed 64-bit maximum
  assign c_sum = 72'(b_day) + 72'(b_rest) + 72'(b_frac);

  always_ff @(posedge clk) begin
    if (c_rdy && b_v) begin
      c_total <= c_sum[62:0];
      c_ovf   <= |c_sum[71:63];
      c_neg   <= b_neg;
      c_st    <= b_st;
      c_stop  <= b_stop;
    end
  end

  // Output register: final status, signed ticks, zero on error
  always_comb begin
    if (c_st != ST_OK) begin
      st_final = c_st;
    end else if (c_ovf) begin
      st_final = ST_OVERFLOW;
    end else begin
      st_final = ST_OK;
    end
    mag = {1'b0, c_total};
    res_next.status = st_final;
    res_next.stop   = c_stop;
    if (st_final != ST_OK) begin
      res_next.ticks = '0;
    end else if (c_neg) begin
      res_next.ticks = 64'd0 - mag;
    end else begin
      res_next.ticks = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && c_v) begin
      res <= res_next;
    end
  end

  assign out_valid = o_v;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    o_v && res.status != ST_OK |-> res.ticks == '0)
    else $error("nonzero ticks with error status");

  a_hold_a: assert property (@(posedge clk) disable iff (rst)
    a_v && !b_rdy |=> a_v && $stable(a_hms))
    else $error("stage a lost or changed while stalled");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !rec_ready |-> a_v && b_v && c_v && o_v && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule

/* rtl/time_span_text_parser.sv */
// Top level of the time span text parser: stream ports around parser and tick pipeline.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata text_char, tuser char_present, tlast last_char
//  m_*     | out | m_tvalid/m_tready  | tdata parse_status, tick_count, stop_position
//
// One character word is taken per cycle while s_tready is high; the parse state updates in that cycle.
// A result word for a word with tlast is registered through the three tick multiply and add
// stages and the output register, and a stall can hold it in any of them.
// rst is synchronous and clears the parse state and the pipeline valids.
// With m_tready low the pipeline holds up to four results before s_tready drops.
`timescale 1ns / 1ps

module time_span_text_parser import tsp_pkg::*; #(
  parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] text_char
  input  logic        s_tuser,   // [0] char_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // [1:0] parse_status, [65:2] tick_count,
                                 // [81:66] stop_position, [87:82] zero
);

  logic     rec_valid;
  logic     rec_ready;
  tsp_rec_t rec;
  tsp_res_t res;

  tsp_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_present(s_tuser),
    .in_last   (s_tlast),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  tsp_ticks u_ticks (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec      (rec),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res      (res)
  );

  // Pack the result word, pad to whole bytes
  assign m_tdata = {6'b0, res};

endmodule
